// ===== rtl/udpb_pkg.sv =====
// ----------------------------------------------------------------------------
// udpb_pkg
// Shared types, constants and the header byte map of the UDP/IPv4 header
// builder.
// ----------------------------------------------------------------------------
package udpb_pkg;

    // header geometry
    localparam int HDR_BYTES = 42;
    localparam int IDX_W     = 6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_BYTES - 1);

    // fixed header fields
    localparam logic [7:0]  BCAST_BYTE   = 8'hFF;
    localparam logic [7:0]  ETYPE_HI     = 8'h08;
    localparam logic [7:0]  IP_VER_IHL   = 8'h45;
    localparam logic [7:0]  IP_TTL       = 8'd64;
    localparam logic [7:0]  IP_PROTO     = 8'd17;
    localparam logic [15:0] IP_HDR_LEN   = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;

    // constant part of the ip header word sum
    localparam logic [15:0] CSUM_INIT = {IP_VER_IHL, 8'h00} + {IP_TTL, IP_PROTO};

    // checksum accumulator
    localparam int          CSUM_ACC_W = 19;
    localparam logic [2:0]  CS_TOT     = 3'd0;
    localparam logic [2:0]  CS_SIP_HI  = 3'd1;
    localparam logic [2:0]  CS_SIP_LO  = 3'd2;
    localparam logic [2:0]  CS_DIP_HI  = 3'd3;
    localparam logic [2:0]  CS_DIP_LO  = 3'd4;
    localparam logic [2:0]  CS_FOLD0   = 3'd5;
    localparam logic [2:0]  CS_FOLD1   = 3'd6;

    // configuration registers
    localparam int          PADDR_W   = 5;
    localparam logic [1:0]  REG_MAC   = 2'd0;
    localparam logic [1:0]  REG_SIP   = 2'd1;
    localparam logic [1:0]  REG_DIP   = 2'd2;
    localparam logic [1:0]  REG_PORT  = 2'd3;
    localparam logic [47:0] MAC_RESET = 48'h0200_DEAD_BEEF;

    // one output beat held by a chain cell
    typedef struct packed {
        logic             vld;
        logic [7:0]       hbyte;
        logic [IDX_W-1:0] idx;
        logic             dropped;
        logic             last;
    } t_beat;

    // cell control
    typedef struct packed {
        logic load;
        logic advance;
    } t_cell_ctl;

    // words that enter the header checksum besides the constant ones
    typedef struct packed {
        logic [15:0] ip_total;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } t_csum_words;

    // checksum status
    typedef struct packed {
        logic        done;
        logic [15:0] sum;
    } t_csum_stat;

    // header byte at a given offset
    function automatic logic [7:0] hdr_byte(
        input logic [IDX_W-1:0] idx,
        input logic [47:0]      mac,
        input logic [31:0]      sip,
        input logic [31:0]      dip,
        input logic [15:0]      port,
        input logic [15:0]      ip_total,
        input logic [15:0]      udp_len,
        input logic [15:0]      csum
    );
        logic [7:0] b;
        b = 8'h00;
        case (idx) inside
            [6'd0:6'd5]: b = BCAST_BYTE;
            6'd6:  b = mac[47:40];
            6'd7:  b = mac[39:32];
            6'd8:  b = mac[31:24];
            6'd9:  b = mac[23:16];
            6'd10: b = mac[15:8];
            6'd11: b = mac[7:0];
            6'd12: b = ETYPE_HI;
            6'd14: b = IP_VER_IHL;
            6'd16: b = ip_total[15:8];
            6'd17: b = ip_total[7:0];
            6'd22: b = IP_TTL;
            6'd23: b = IP_PROTO;
            6'd24: b = csum[15:8];
            6'd25: b = csum[7:0];
            6'd26: b = sip[31:24];
            6'd27: b = sip[23:16];
            6'd28: b = sip[15:8];
            6'd29: b = sip[7:0];
            6'd30: b = dip[31:24];
            6'd31: b = dip[23:16];
            6'd32: b = dip[15:8];
            6'd33: b = dip[7:0];
            6'd34, 6'd36: b = port[15:8];
            6'd35, 6'd37: b = port[7:0];
            6'd38: b = udp_len[15:8];
            6'd39: b = udp_len[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/udpb_ifs.sv =====
// ----------------------------------------------------------------------------
// udpb channel interfaces
// Valid/ready channels for packet requests and for header bytes.
// ----------------------------------------------------------------------------
interface udpb_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_len;
    logic        slot_free;

    modport source (output valid, output data_len, output slot_free, input ready);
    modport sink   (input valid, input data_len, input slot_free, output ready);
endinterface

interface udpb_hdr_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic [5:0] byte_index;
    logic       dropped;
    logic       last;

    modport source (output valid, output header_byte, output byte_index,
                    output dropped, output last, input ready);
    modport sink   (input valid, input header_byte, input byte_index,
                    input dropped, input last, output ready);
endinterface

// ===== rtl/udpb_cell.sv =====
// ----------------------------------------------------------------------------
// udpb_cell
// One byte cell of the output chain: loads a header beat or takes the beat
// of its upstream neighbor when the chain advances.
// ----------------------------------------------------------------------------
module udpb_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  udpb_pkg::t_cell_ctl i_ctl,
    input  udpb_pkg::t_beat     i_load_beat,
    input  udpb_pkg::t_beat     i_next_beat,
    output udpb_pkg::t_beat     o_beat
);

    udpb_pkg::t_beat r_beat;
    udpb_pkg::t_beat n_beat;

    // load wins over shift
    always_comb begin
        n_beat = r_beat;
        if (i_ctl.load) begin
            n_beat = i_load_beat;
        end else if (i_ctl.advance) begin
            n_beat = i_next_beat;
        end
    end

    // valid bit is reset, payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else begin
            r_beat.vld <= n_beat.vld;
        end
        r_beat.hbyte   <= n_beat.hbyte;
        r_beat.idx     <= n_beat.idx;
        r_beat.dropped <= n_beat.dropped;
        r_beat.last    <= n_beat.last;
    end

    assign o_beat = r_beat;

endmodule

// ===== rtl/udpb_csum.sv =====
// ----------------------------------------------------------------------------
// udpb_csum
// IPv4 header checksum: adds one variable header word per cycle, folds the
// carries back in twice and returns the complement.
// ----------------------------------------------------------------------------
module udpb_csum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  udpb_pkg::t_csum_words i_words,
    output udpb_pkg::t_csum_stat  o_stat
);

    logic [udpb_pkg::CSUM_ACC_W-1:0] r_acc;
    logic [udpb_pkg::CSUM_ACC_W-1:0] n_acc;
    logic [2:0]                      r_step;
    logic                            r_run;
    logic                            r_fin;
    logic [15:0]                     w_word;

    // word picked for this step
    always_comb begin
        case (r_step)
            udpb_pkg::CS_TOT:    w_word = i_words.ip_total;
            udpb_pkg::CS_SIP_HI: w_word = i_words.src_ip[31:16];
            udpb_pkg::CS_SIP_LO: w_word = i_words.src_ip[15:0];
            udpb_pkg::CS_DIP_HI: w_word = i_words.dst_ip[31:16];
            udpb_pkg::CS_DIP_LO: w_word = i_words.dst_ip[15:0];
            default:             w_word = 16'h0000;
        endcase
    end

    // accumulate, then fold
    always_comb begin
        if (r_step == udpb_pkg::CS_FOLD0 || r_step == udpb_pkg::CS_FOLD1) begin
            n_acc = {3'b000, r_acc[15:0]} + udpb_pkg::CSUM_ACC_W'(r_acc[18:16]);
        end else begin
            n_acc = r_acc + udpb_pkg::CSUM_ACC_W'(w_word);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_step <= udpb_pkg::CS_TOT;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_fin  <= 1'b0;
            r_step <= udpb_pkg::CS_TOT;
        end else if (r_run) begin
            r_step <= r_step + 3'd1;
            if (r_step == udpb_pkg::CS_FOLD1) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
    end

    // accumulator datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= udpb_pkg::CSUM_ACC_W'(udpb_pkg::CSUM_INIT);
        end else if (r_run) begin
            r_acc <= n_acc;
        end
    end

    assign o_stat.done = r_fin;
    assign o_stat.sum  = ~r_acc[15:0];

endmodule

// ===== rtl/udp_ipv4_header_builder.sv =====
// ----------------------------------------------------------------------------
// udp_ipv4_header_builder
// Builds the 42-byte Ethernet/IPv4/UDP header for each packet request with a free
// slot and streams it out one byte per transaction through a chain of byte cells.
// ----------------------------------------------------------------------------
// the first header byte follows request acceptance once the checksum sequencer is done
// a new request is taken as soon as the previous one has entered the cell chain, and
//   is loaded once the byte-wide cell chain has drained; a dropped request takes one
//   output transaction and still waits for the serial checksum sequencer
// reset: synchronous active low; clears chain valid bits and request state,
//   config registers return to their reset values
// ----------------------------------------------------------------------------
module udp_ipv4_header_builder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    udpb_req_if.sink                     i_req,
    udpb_hdr_if.source                   o_hdr,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [udpb_pkg::PADDR_W-1:0] paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);

    // configuration registers
    logic [47:0] r_mac;
    logic [31:0] r_sip;
    logic [31:0] r_dip;
    logic [15:0] r_port;
    logic        w_cfg_wr;
    logic [1:0]  w_reg_sel;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_sel = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac  <= udpb_pkg::MAC_RESET;
            r_sip  <= 32'h0;
            r_dip  <= 32'h0;
            r_port <= 16'h0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_sel)
                udpb_pkg::REG_MAC:  r_mac  <= pwdata[47:0];
                udpb_pkg::REG_SIP:  r_sip  <= pwdata[31:0];
                udpb_pkg::REG_DIP:  r_dip  <= pwdata[31:0];
                udpb_pkg::REG_PORT: r_port <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_reg_sel)
            udpb_pkg::REG_MAC:  prdata = {16'h0, r_mac};
            udpb_pkg::REG_SIP:  prdata = {32'h0, r_sip};
            udpb_pkg::REG_DIP:  prdata = {32'h0, r_dip};
            udpb_pkg::REG_PORT: prdata = {48'h0, r_port};
            default:            prdata = 64'h0;
        endcase
    end

    // request holding register
    logic        r_req_vld;
    logic [15:0] r_req_len;
    logic        r_req_free;
    logic        w_req_take;
    logic        w_load;

    assign i_req.ready = !r_req_vld;
    assign w_req_take  = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (w_req_take) begin
            r_req_vld <= 1'b1;
        end else if (w_load) begin
            r_req_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_take) begin
            r_req_len  <= i_req.data_len;
            r_req_free <= i_req.slot_free;
        end
    end

    // length fields wrap at 16 bits
    logic [15:0] w_ip_total;
    logic [15:0] w_udp_len;

    assign w_udp_len  = r_req_len + udpb_pkg::UDP_HDR_LEN;
    assign w_ip_total = w_udp_len + udpb_pkg::IP_HDR_LEN;

    // header checksum
    udpb_pkg::t_csum_words w_cs_words;
    udpb_pkg::t_csum_stat  w_cs_stat;

    assign w_cs_words.ip_total = w_ip_total;
    assign w_cs_words.src_ip   = r_sip;
    assign w_cs_words.dst_ip   = r_dip;

    udpb_csum u_csum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_req_take),
        .i_words (w_cs_words),
        .o_stat  (w_cs_stat)
    );

    // chain occupancy and load decision
    logic [udpb_pkg::IDX_W-1:0] r_cnt;
    udpb_pkg::t_beat            w_beat [udpb_pkg::HDR_BYTES];
    udpb_pkg::t_cell_ctl        w_ctl;
    logic                       w_out_take;
    logic                       w_can_load;

    assign w_out_take = w_beat[0].vld && o_hdr.ready;
    assign w_can_load = (r_cnt == '0) || (r_cnt == udpb_pkg::IDX_W'(1) && o_hdr.ready);
    assign w_load     = r_req_vld && w_cs_stat.done && w_can_load;

    assign w_ctl.load    = w_load;
    assign w_ctl.advance = o_hdr.ready || !w_beat[0].vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_load) begin
            r_cnt <= r_req_free ? udpb_pkg::IDX_W'(udpb_pkg::HDR_BYTES)
                                : udpb_pkg::IDX_W'(1);
        end else if (w_out_take) begin
            r_cnt <= r_cnt - udpb_pkg::IDX_W'(1);
        end
    end

    // chain of byte cells, cell 0 drives the output
    for (genvar k = 0; k < udpb_pkg::HDR_BYTES; k++) begin : g_cell
        udpb_pkg::t_beat w_load_beat;
        udpb_pkg::t_beat w_next_beat;

        always_comb begin
            w_load_beat.idx = udpb_pkg::IDX_W'(k);
            if (r_req_free) begin
                w_load_beat.vld     = 1'b1;
                w_load_beat.dropped = 1'b0;
                w_load_beat.last    = (udpb_pkg::IDX_W'(k) == udpb_pkg::LAST_IDX);
                w_load_beat.hbyte   = udpb_pkg::hdr_byte(udpb_pkg::IDX_W'(k), r_mac,
                                                         r_sip, r_dip, r_port, w_ip_total,
                                                         w_udp_len, w_cs_stat.sum);
            end else begin
                w_load_beat.vld     = (k == 0);
                w_load_beat.dropped = 1'b1;
                w_load_beat.last    = 1'b1;
                w_load_beat.hbyte   = 8'h00;
            end
        end

        if (k == udpb_pkg::HDR_BYTES - 1) begin : g_tail
            assign w_next_beat = '0;
        end else begin : g_body
            assign w_next_beat = w_beat[k+1];
        end

        udpb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_load_beat (w_load_beat),
            .i_next_beat (w_next_beat),
            .o_beat      (w_beat[k])
        );
    end

    // output channel
    assign o_hdr.valid       = w_beat[0].vld;
    assign o_hdr.header_byte = w_beat[0].hbyte;
    assign o_hdr.byte_index  = w_beat[0].idx;
    assign o_hdr.dropped     = w_beat[0].dropped;
    assign o_hdr.last        = w_beat[0].last;

endmodule
